// File: hw/rtl/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared constants and types for the de Casteljau subdivision block.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int DEF_MAX_POINTS  = 16;
    localparam int DEF_COORD_WIDTH = 32;

    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;
    localparam int IDX_W    = 4;
    localparam int T_W      = 17;
    localparam int T_FRAC   = 16;
    localparam int T_ONE    = 65536;
    localparam int T_HALF   = 32768;
    localparam int NUM_AXES = 3;

    typedef struct packed {
        logic load;
        logic put;
        logic shift;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/bdc_cell.sv
// ----------------------------------------------------------------------------
// bdc_cell
// One chain cell: holds one 3D point, loads, takes a result or shifts.
// ----------------------------------------------------------------------------
module bdc_cell import bdc_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                          aclk,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [COORD_WIDTH-1:0] load_pt [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] next_pt [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] res_pt  [NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] pt      [NUM_AXES]
);

    logic signed [COORD_WIDTH-1:0] pt_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_AXES; c++) begin
            if (ctrl.load) begin
                pt_reg[c] <= load_pt[c];
            end else if (ctrl.put) begin
                pt_reg[c] <= res_pt[c];
            end else if (ctrl.shift) begin
                pt_reg[c] <= next_pt[c];
            end
        end
    end

    assign pt = pt_reg;

endmodule

// File: hw/rtl/bdc_lerp.sv
// ----------------------------------------------------------------------------
// bdc_lerp
// Two-stage 3D interpolation a*(1-t)+b*t, rounded half up, saturated.
// ----------------------------------------------------------------------------
module bdc_lerp import bdc_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [T_W-1:0]                t,
    input  logic signed [COORD_WIDTH-1:0] a [NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] b [NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] r [NUM_AXES],
    output logic                          sat
);

    localparam int PW = COORD_WIDTH + T_W + 1;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] LMAX =
        {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] LMIN = ~LMAX;

    logic signed [T_W:0]  wa;
    logic signed [T_W:0]  wb;
    logic signed [PW-1:0] pa_reg [NUM_AXES];
    logic signed [PW-1:0] pb_reg [NUM_AXES];
    logic signed [SW-1:0] sum    [NUM_AXES];
    logic signed [SW-1:0] sh     [NUM_AXES];
    logic [NUM_AXES-1:0]  sat_c;

    assign wa = signed'({1'b0, T_W'(T_ONE) - t});
    assign wb = signed'({1'b0, t});

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                pa_reg[c] <= a[c] * wa;
                pb_reg[c] <= b[c] * wb;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            sum[c]   = SW'(pa_reg[c]) + SW'(pb_reg[c]) + SW'(T_HALF);
            sh[c]    = sum[c] >>> T_FRAC;
            sat_c[c] = 1'b0;
            if (sh[c] > LMAX) begin
                r[c]     = LMAX[COORD_WIDTH-1:0];
                sat_c[c] = 1'b1;
            end else if (sh[c] < LMIN) begin
                r[c]     = LMIN[COORD_WIDTH-1:0];
                sat_c[c] = 1'b1;
            end else begin
                r[c] = sh[c][COORD_WIDTH-1:0];
            end
        end
    end

    assign sat = |sat_c;

endmodule

// File: hw/rtl/bezier_de_casteljau_subdivide.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_subdivide
// Splits a 3D Bezier curve at t with a chain of point cells.
// ----------------------------------------------------------------------------
// Control points load one per cycle into the cell chain; the request marked
// last carries t and starts the split. A single two-stage interpolation unit
// works on the first two cells while the chain shifts toward it: a multiply
// step and an accumulate step per interpolation, then a drop step per level
// to remove the spent point. Results then leave from the lower and upper
// point memories, one per control point, in index order, each read and then
// held until accepted. No new curve is taken until the last result is
// accepted.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_subdivide import bdc_pkg::*; #(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_point_x,
    input  logic signed [IN_W-1:0]  s_point_y,
    input  logic signed [IN_W-1:0]  s_point_z,
    input  logic [T_W-1:0]          s_split_t,
    input  logic                    s_last_point,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_point_index,
    output logic signed [OUT_W-1:0] m_lower_x,
    output logic signed [OUT_W-1:0] m_lower_y,
    output logic signed [OUT_W-1:0] m_lower_z,
    output logic signed [OUT_W-1:0] m_upper_x,
    output logic signed [OUT_W-1:0] m_upper_y,
    output logic signed [OUT_W-1:0] m_upper_z,
    output logic                    m_overflow_seen,
    output logic                    m_last_result
);

    localparam int CW   = COORD_WIDTH;
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int EW   = (CW > IN_W) ? CW : IN_W;
    localparam int RW   = NUM_AXES * CW;
    localparam logic signed [EW-1:0] CMAX =
        {{(EW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [EW-1:0] CMIN = ~CMAX;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DROP = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [IW-1:0]   w_reg, w_next;
    logic [IW-1:0]   j_reg, j_next;
    logic [IW-1:0]   k_reg, k_next;
    logic [T_W-1:0]  t_reg, t_next;
    logic            ovf_reg, ovf_next;

    logic signed [EW-1:0] in_ext [NUM_AXES];
    logic signed [CW-1:0] in_pt  [NUM_AXES];
    logic                 in_clip;
    logic                 accept;
    logic                 store;
    logic [CNTW-1:0]      n_new;

    logic signed [CW-1:0] cell_pt [MAX_POINTS][NUM_AXES];
    logic signed [CW-1:0] nbr_pt  [MAX_POINTS][NUM_AXES];
    cell_ctrl_t           cell_ctrl [MAX_POINTS];

    logic signed [CW-1:0] res_pt [NUM_AXES];
    logic                 res_sat;

    logic [RW-1:0] lower_mem [MAX_POINTS];
    logic [RW-1:0] upper_mem [MAX_POINTS];
    logic [RW-1:0] lo_rd_reg, up_rd_reg;
    logic [RW-1:0] in_row, res_row;

    logic signed [EW-1:0] lo_ext [NUM_AXES];
    logic signed [EW-1:0] up_ext [NUM_AXES];

    // input capture and saturation
    always_comb begin
        in_ext[0] = EW'(s_point_x);
        in_ext[1] = EW'(s_point_y);
        in_ext[2] = EW'(s_point_z);
        in_clip   = 1'b0;
        for (int c = 0; c < NUM_AXES; c++) begin
            if (in_ext[c] > CMAX) begin
                in_pt[c] = CMAX[CW-1:0];
                in_clip  = 1'b1;
            end else if (in_ext[c] < CMIN) begin
                in_pt[c] = CMIN[CW-1:0];
                in_clip  = 1'b1;
            end else begin
                in_pt[c] = in_ext[c][CW-1:0];
            end
        end
    end

    assign accept = s_valid && s_ready;
    assign store  = accept && (count_reg < CNTW'(MAX_POINTS));
    assign n_new  = store ? count_reg + CNTW'(1) : count_reg;

    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            in_row[c*CW +: CW]  = in_pt[c];
            res_row[c*CW +: CW] = res_pt[c];
        end
    end

    // cell chain
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            cell_ctrl[i].load  = store && (count_reg == CNTW'(i));
            cell_ctrl[i].put   = (state_reg == ST_ACC) && (IW'(i) == w_reg);
            cell_ctrl[i].shift = ((state_reg == ST_ACC) || (state_reg == ST_DROP))
                                 && (IW'(i) < w_reg);
        end
    end

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_chain
        if (i == MAX_POINTS - 1) begin : g_tail
            assign nbr_pt[i] = cell_pt[i];
        end else begin : g_body
            assign nbr_pt[i] = cell_pt[i+1];
        end
        bdc_cell #(
            .COORD_WIDTH(CW)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl[i]),
            .load_pt (in_pt),
            .next_pt (nbr_pt[i]),
            .res_pt  (res_pt),
            .pt      (cell_pt[i])
        );
    end

    bdc_lerp #(
        .COORD_WIDTH(CW)
    ) u_lerp (
        .aclk (aclk),
        .en   (state_reg == ST_MUL),
        .t    (t_reg),
        .a    (cell_pt[0]),
        .b    (cell_pt[1]),
        .r    (res_pt),
        .sat  (res_sat)
    );

    // result memories
    always_ff @(posedge aclk) begin
        if (store && (count_reg == '0)) begin
            lower_mem[0] <= in_row;
        end else if ((state_reg == ST_ACC) && (j_reg == '0)) begin
            lower_mem[IW'(count_reg - CNTW'(w_reg))] <= res_row;
        end
        if (store) begin
            upper_mem[count_reg[IW-1:0]] <= in_row;
        end else if ((state_reg == ST_ACC) && (j_reg == w_reg - IW'(1))) begin
            upper_mem[w_reg - IW'(1)] <= res_row;
        end
        if (state_reg == ST_RD) begin
            lo_rd_reg <= lower_mem[k_reg];
            up_rd_reg <= upper_mem[k_reg];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        w_next     = w_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    count_next = n_new;
                    ovf_next   = ovf_reg || !store || in_clip;
                    if (s_last_point) begin
                        t_next = (s_split_t > T_W'(T_ONE)) ? T_W'(T_ONE) : s_split_t;
                        w_next = IW'(n_new - CNTW'(1));
                        j_next = '0;
                        k_next = '0;
                        state_next = (n_new == CNTW'(1)) ? ST_RD : ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                ovf_next = ovf_reg || res_sat;
                j_next   = j_reg + IW'(1);
                state_next = (j_reg == w_reg - IW'(1)) ? ST_DROP : ST_MUL;
            end
            ST_DROP: begin
                w_next = w_reg - IW'(1);
                j_next = '0;
                k_next = '0;
                state_next = (w_reg == IW'(1)) ? ST_RD : ST_MUL;
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (m_last_result) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
        w_reg <= w_next;
        j_reg <= j_next;
        k_reg <= k_next;
        t_reg <= t_next;
    end

    // outputs
    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            lo_ext[c] = EW'(signed'(lo_rd_reg[c*CW +: CW]));
            up_ext[c] = EW'(signed'(up_rd_reg[c*CW +: CW]));
        end
    end

    assign s_ready         = (state_reg == ST_LOAD);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_point_index   = IDX_W'(k_reg);
    assign m_lower_x       = lo_ext[0][OUT_W-1:0];
    assign m_lower_y       = lo_ext[1][OUT_W-1:0];
    assign m_lower_z       = lo_ext[2][OUT_W-1:0];
    assign m_upper_x       = up_ext[0][OUT_W-1:0];
    assign m_upper_y       = up_ext[1][OUT_W-1:0];
    assign m_upper_z       = up_ext[2][OUT_W-1:0];
    assign m_overflow_seen = ovf_reg;
    assign m_last_result   = (CNTW'(k_reg) == count_reg - CNTW'(1));

endmodule

// File: hw/rtl/bdc_checker.sv
// ----------------------------------------------------------------------------
// bdc_checker
// Port-level checks for the subdivision block, bound to the top level.
// ----------------------------------------------------------------------------
module bdc_checker import bdc_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic signed [IN_W-1:0]  s_point_x,
    input logic signed [IN_W-1:0]  s_point_y,
    input logic signed [IN_W-1:0]  s_point_z,
    input logic [T_W-1:0]          s_split_t,
    input logic                    s_last_point,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [IDX_W-1:0]        m_point_index,
    input logic signed [OUT_W-1:0] m_lower_x,
    input logic signed [OUT_W-1:0] m_lower_y,
    input logic signed [OUT_W-1:0] m_lower_z,
    input logic signed [OUT_W-1:0] m_upper_x,
    input logic signed [OUT_W-1:0] m_upper_y,
    input logic signed [OUT_W-1:0] m_upper_z,
    input logic                    m_overflow_seen,
    input logic                    m_last_result
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("loading while emitting results");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lower_x) && $stable(m_upper_x)
            && $stable(m_point_index))
        else $error("stalled result changed");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_result |=> !m_valid && s_ready)
        else $error("no return to loading after last result");

    a_run_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=> !s_ready)
        else $error("loading before run finished");

endmodule

bind bezier_de_casteljau_subdivide bdc_checker u_bdc_checker (.*);

// File: bench/bezier_de_casteljau_subdivide_tb.sv
// ----------------------------------------------------------------------------
// bezier_de_casteljau_subdivide_tb
// Streams curves of control points into the block, splits them at t in a
// behavioral de Casteljau predictor and checks every lower/upper point pair.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_subdivide_tb;
    import bdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CAP        = DEF_MAX_POINTS;
    localparam int  STALL_LIMIT = 20000;
    localparam longint CMAX    = 64'sd2147483647;
    localparam longint CMIN    = -64'sd2147483648;

    typedef struct {
        logic signed [IN_W-1:0] x, y, z;
        logic [T_W-1:0]         t;
        logic                   last;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [OUT_W-1:0] lx, ly, lz, ux, uy, uz;
        logic                    ovf, last;
    } pair_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, s_last_point = 0;
    logic signed [IN_W-1:0] s_point_x = 0, s_point_y = 0, s_point_z = 0;
    logic [T_W-1:0] s_split_t = 0;
    logic m_valid, m_ready = 0, m_overflow_seen, m_last_result;
    logic [IDX_W-1:0] m_point_index;
    logic signed [OUT_W-1:0] m_lower_x, m_lower_y, m_lower_z;
    logic signed [OUT_W-1:0] m_upper_x, m_upper_y, m_upper_z;

    bezier_de_casteljau_subdivide dut (.*);

    always #2 aclk = ~aclk;

    request_t pending[$];
    pair_t    expected_pairs[$];
    int       errors = 0, idle_cycles = 0;

    // predictor state
    longint pts[CAP][NUM_AXES];
    int     loaded = 0;
    bit     dropped = 0;

    function automatic longint lerp_q16(longint a, longint b, longint t);
        longint s;
        s = a * (T_ONE - t) + b * t + T_HALF;
        return s >>> T_FRAC;
    endfunction

    task automatic split_curve(request_t r);
        longint lo[CAP][NUM_AXES], up[CAP][NUM_AXES];
        longint t;
        int n;
        pair_t p;
        if (loaded < CAP) begin
            pts[loaded][0] = longint'(r.x);
            pts[loaded][1] = longint'(r.y);
            pts[loaded][2] = longint'(r.z);
            loaded++;
        end else begin
            dropped = 1;
        end
        if (!r.last) return;
        t = (r.t > T_ONE) ? T_ONE : r.t;
        n = loaded;
        for (int c = 0; c < NUM_AXES; c++) begin
            lo[0][c] = pts[0][c];
            up[n-1][c] = pts[n-1][c];
        end
        for (int lv = 1; lv < n; lv++) begin
            for (int j = 0; j < n - lv; j++)
                for (int c = 0; c < NUM_AXES; c++) begin
                    pts[j][c] = lerp_q16(pts[j][c], pts[j+1][c], t);
                    if (pts[j][c] > CMAX) begin pts[j][c] = CMAX; dropped = 1; end
                    if (pts[j][c] < CMIN) begin pts[j][c] = CMIN; dropped = 1; end
                end
            for (int c = 0; c < NUM_AXES; c++) begin
                lo[lv][c] = pts[0][c];
                up[n-1-lv][c] = pts[n-1-lv][c];
            end
        end
        for (int k = 0; k < n; k++) begin
            p.idx = k[IDX_W-1:0];
            p.lx = OUT_W'(lo[k][0]); p.ly = OUT_W'(lo[k][1]); p.lz = OUT_W'(lo[k][2]);
            p.ux = OUT_W'(up[k][0]); p.uy = OUT_W'(up[k][1]); p.uz = OUT_W'(up[k][2]);
            p.ovf = dropped;
            p.last = (k == n - 1);
            expected_pairs.push_back(p);
        end
        loaded = 0;
        dropped = 0;
    endtask

    function automatic logic signed [IN_W-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
        endcase
    endfunction

    task automatic add_curve(int n, logic [T_W-1:0] t, int mode);
        request_t r;
        for (int i = 0; i < n; i++) begin
            r.x = rand_coord(mode); r.y = rand_coord(mode); r.z = rand_coord(mode);
            r.t = T_W'($urandom_range(0, 131071));
            r.last = (i == n - 1);
            if (r.last) r.t = t;
            pending.push_back(r);
        end
    endtask

    // accept flag sampled at the rising edge
    logic s_ready_q = 0;
    always @(posedge aclk) s_ready_q <= s_valid && s_ready;

    logic m_fire_q = 0;
    always @(posedge aclk) m_fire_q <= m_valid && m_ready;

    // driver
    int gap_s = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_q) begin
                s_valid <= 0;
                gap_s = $urandom_range(0, 11);
            end else if (!s_valid) begin
                if (gap_s > 0) gap_s--;
                else if (pending.size() > 0) begin
                    request_t r;
                    r = pending.pop_front();
                    s_point_x <= r.x; s_point_y <= r.y; s_point_z <= r.z;
                    s_split_t <= r.t; s_last_point <= r.last;
                    s_valid <= 1;
                    split_curve(r);
                end
            end
        end
    end

    // receiver stalls
    int gap_m = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_ready && m_fire_q) begin
                gap_m = $urandom_range(0, 11);
                m_ready <= (gap_m == 0);
            end else if (!m_ready) begin
                if (gap_m > 0) gap_m--;
                m_ready <= (gap_m == 0);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected pair idx=%0d", m_point_index);
                end else begin
                    pair_t e;
                    e = expected_pairs.pop_front();
                    if (e.idx !== m_point_index || e.lx !== m_lower_x ||
                        e.ly !== m_lower_y || e.lz !== m_lower_z ||
                        e.ux !== m_upper_x || e.uy !== m_upper_y ||
                        e.uz !== m_upper_z || e.ovf !== m_overflow_seen ||
                        e.last !== m_last_result) begin
                        errors++;
                        if (errors <= 10)
                            $display("exp %0d L(%h %h %h) U(%h %h %h) o%b l%b / got %0d L(%h %h %h) U(%h %h %h) o%b l%b",
                                e.idx, e.lx, e.ly, e.lz, e.ux, e.uy, e.uz, e.ovf, e.last,
                                m_point_index, m_lower_x, m_lower_y, m_lower_z,
                                m_upper_x, m_upper_y, m_upper_z, m_overflow_seen,
                                m_last_result);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("bezier_de_casteljau_subdivide: mismatch");
            $finish;
        end
    end

    initial begin
        int n;
        // directed: single point, pair, extremes of t, full and overfull curves
        add_curve(1, 17'd30000, 3);
        add_curve(2, 17'd0, 1);
        add_curve(2, 17'd65536, 2);
        add_curve(3, 17'd131071, 0);
        add_curve(3, 17'd32768, 0);
        add_curve(CAP, 17'd21845, 3);
        add_curve(CAP + 2, 17'd40000, 3);
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        while (pending.size() < 260) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP, CAP + 3)
                                            : $urandom_range(1, 6);
            add_curve(n, ($urandom_range(0, 7) == 0) ? T_W'($urandom_range(0, 131071))
                                                     : T_W'($urandom_range(0, 65536)),
                      $urandom_range(0, 5));
        end
        wait (pending.size() == 0 && !s_valid && expected_pairs.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_pairs.size() == 0)
            $display("bezier_de_casteljau_subdivide: match");
        else
            $display("bezier_de_casteljau_subdivide: mismatch");
        $finish;
    end
endmodule
